// ===== src/srq_pkg.sv =====
// srq_pkg: shared constants, command/status codes and cell control struct
// for the stable sorted ready queue. No dependencies.
`default_nettype none
package srq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int KEY_BITS    = 16;
    localparam int ID_BITS     = 8;
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam int STATUS_BITS = 2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    localparam logic MODE_ARRIVAL = 1'b0;
    localparam logic MODE_SORTED  = 1'b1;

    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

    // per-cell control from the queue controller
    typedef struct packed {
        logic ins;     // insert this cycle
        logic pop;     // pop this cycle
        logic sorted;  // sorted insert mode
        logic occ;     // cell holds a live entry
        logic tail;    // cell is the first free slot
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== src/srq_cell.sv =====
// srq_cell: one slot of the queue; holds an (id, key) entry and shifts with
// its neighbors on insert and pop. Depends on srq_pkg.
`default_nettype none
module srq_cell (
    input  wire                         aclk,
    input  srq_pkg::cell_ctrl_t         ctrl,
    input  wire  [srq_pkg::KEY_BITS-1:0] new_key,
    input  wire  [srq_pkg::ID_BITS-1:0]  new_id,
    input  wire  [srq_pkg::KEY_BITS-1:0] left_key,
    input  wire  [srq_pkg::ID_BITS-1:0]  left_id,
    input  wire  [srq_pkg::KEY_BITS-1:0] right_key,
    input  wire  [srq_pkg::ID_BITS-1:0]  right_id,
    input  wire                         found_in,
    output logic                        found_out,
    output logic [srq_pkg::KEY_BITS-1:0] key_reg,
    output logic [srq_pkg::ID_BITS-1:0]  id_reg
);

    logic gt;

    // strictly greater keeps equal keys in arrival order
    assign gt        = ctrl.sorted && ctrl.occ && (key_reg > new_key);
    assign found_out = found_in | gt;

    always_ff @(posedge aclk) begin
        if (ctrl.ins) begin
            if (found_in) begin
                key_reg <= left_key;
                id_reg  <= left_id;
            end else if (gt || ctrl.tail) begin
                key_reg <= new_key;
                id_reg  <= new_id;
            end
        end else if (ctrl.pop) begin
            key_reg <= right_key;
            id_reg  <= right_id;
        end
    end

endmodule
`default_nettype wire

// ===== src/stable_sorted_ready_queue.sv =====
// stable_sorted_ready_queue: top level; a row of srq_cell slots, the fill
// counter, the APB mode register and the result register. Depends on srq_pkg.
//
// Usage:
//   s_ channel carries commands: s_tuser is the command (insert or pop),
//   s_tdata holds the entry id and key. m_ channel returns one result per
//   command: m_tuser is the status, m_tdata the popped entry, the count and
//   the head key with its valid flag.
//   Every slot compares its key with the new key in parallel and shifts in
//   the same cycle, so one command is taken per cycle unless the receiver
//   stalls; the result is registered and appears in the cycle after acceptance.
//   If the receiver stalls with a result pending, s_tready drops until that
//   result is taken; a command is taken in the same cycle the result leaves.
//   Reset (aresetn low, synchronous) empties the queue and sets order_mode
//   to sorted. order_mode at APB address 0 must be written only while idle;
//   the block does not enforce it; a mode change never reorders stored entries.
`default_nettype none
module stable_sorted_ready_queue (
    input  wire         aclk,
    input  wire         aresetn,
    // s_tdata: entry_id [7:0], entry_key [23:8]
    input  wire  [23:0] s_tdata,
    // s_tuser: cmd [0]
    input  wire  [0:0]  s_tuser,
    input  wire         s_tvalid,
    output logic        s_tready,
    // m_tdata: popped_id [7:0], popped_key [23:8], entry_count [28:24],
    //          head_valid [29], head_key [45:30], zero [47:46]
    output logic [47:0] m_tdata,
    // m_tuser: status [1:0]
    output logic [1:0]  m_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int N  = srq_pkg::QUEUE_DEPTH;
    localparam int KB = srq_pkg::KEY_BITS;
    localparam int IB = srq_pkg::ID_BITS;
    localparam int CB = srq_pkg::CNT_BITS;

    logic [CB-1:0] count_reg, count_next;
    logic          mode_reg;
    logic          m_tvalid_reg;
    logic [srq_pkg::STATUS_BITS-1:0] status_reg, status_next;
    logic [IB-1:0] pid_reg, pid_next;
    logic [KB-1:0] pkey_reg, pkey_next;
    logic [CB-1:0] cnt_out_reg;
    logic          hvalid_reg;
    logic [KB-1:0] hkey_reg, hkey_next;

    logic [KB-1:0] new_key;
    logic [IB-1:0] new_id;
    logic          accept, is_insert, full, empty, do_ins, do_pop;

    logic [KB-1:0] key_q [N];
    logic [IB-1:0] id_q  [N];
    logic [N:0]    found;

    assign new_id  = s_tdata[IB-1:0];
    assign new_key = s_tdata[IB+KB-1:IB];

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign is_insert = (s_tuser[0] == srq_pkg::CMD_INSERT);
    assign full      = (count_reg == CB'(N));
    assign empty     = (count_reg == '0);
    assign do_ins    = accept && is_insert && !full;
    assign do_pop    = accept && !is_insert && !empty;

    assign found[0] = 1'b0;

    for (genvar i = 0; i < N; i++) begin : g_cell
        srq_pkg::cell_ctrl_t c;
        logic [KB-1:0] lk, rk;
        logic [IB-1:0] li, ri;

        assign c.ins    = do_ins;
        assign c.pop    = do_pop;
        assign c.sorted = (mode_reg == srq_pkg::MODE_SORTED);
        assign c.occ    = (CB'(i) < count_reg);
        assign c.tail   = (CB'(i) == count_reg);

        if (i == 0) begin : g_first
            assign lk = new_key;
            assign li = new_id;
        end else begin : g_mid
            assign lk = key_q[i-1];
            assign li = id_q[i-1];
        end

        if (i == N - 1) begin : g_last
            assign rk = key_q[i];
            assign ri = id_q[i];
        end else begin : g_inner
            assign rk = key_q[i+1];
            assign ri = id_q[i+1];
        end

        srq_cell u_cell (
            .aclk      (aclk),
            .ctrl      (c),
            .new_key   (new_key),
            .new_id    (new_id),
            .left_key  (lk),
            .left_id   (li),
            .right_key (rk),
            .right_id  (ri),
            .found_in  (found[i]),
            .found_out (found[i+1]),
            .key_reg   (key_q[i]),
            .id_reg    (id_q[i])
        );
    end

    // result of the command being accepted, from the state before it
    always_comb begin
        status_next = srq_pkg::ST_OK;
        pid_next    = '0;
        pkey_next   = '0;
        count_next  = count_reg;
        hkey_next   = empty ? '0 : key_q[0];
        if (is_insert) begin
            if (full) begin
                status_next = srq_pkg::ST_FULL;
            end else begin
                count_next = count_reg + CB'(1);
                // new entry is head if empty, or if sorted and head key is greater
                if (empty || found[1]) begin
                    hkey_next = new_key;
                end
            end
        end else begin
            if (empty) begin
                status_next = srq_pkg::ST_EMPTY;
            end else begin
                pid_next   = id_q[0];
                pkey_next  = key_q[0];
                count_next = count_reg - CB'(1);
                hkey_next  = (count_reg > CB'(1)) ? key_q[1] : '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            mode_reg     <= srq_pkg::MODE_SORTED;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr[2] == 1'b0) begin
                mode_reg <= pwdata[0];
            end
            if (accept) begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg  <= status_next;
            pid_reg     <= pid_next;
            pkey_reg    <= pkey_next;
            cnt_out_reg <= count_next;
            hvalid_reg  <= (count_next != '0);
            hkey_reg    <= hkey_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {2'b00, hkey_reg, hvalid_reg, cnt_out_reg, pkey_reg, pid_reg};

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {31'd0, mode_reg} : 32'd0;

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// tb: self-checking bench for stable_sorted_ready_queue. Drives commands on the
// s_ stream, checks every m_ result against a behavioral queue model or a
// table row; switches order_mode over APB between phases. Depends on srq_pkg.
`timescale 1ns / 100ps
`default_nettype none
module tb;

    localparam int          WDOG_LIMIT     = 1000;
    localparam int          PHASE_ITEMS    = 128;
    localparam logic [2:0]  REG_ORDER_MODE = 3'd0;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  pid;
        logic [15:0] pkey;
        logic [4:0]  cnt;
        logic        hv;
        logic [15:0] hkey;
    } qres_t;

    typedef struct {
        logic        cmd;
        logic [7:0]  id;
        logic [15:0] key;
        int          reps;
        bit          typed;
        qres_t       want;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [23:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    wire  [47:0] m_tdata;
    wire  [1:0]  m_tuser;
    wire         m_tvalid;
    logic        m_tready = 1'b1;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire  [31:0] prdata;
    wire         pready;

    stable_sorted_ready_queue u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 aclk = ~aclk;

    // queue model state
    logic [15:0] mdl_key [srq_pkg::QUEUE_DEPTH];
    logic [7:0]  mdl_id  [srq_pkg::QUEUE_DEPTH];
    int          mdl_fill = 0;
    logic        mdl_sorted = srq_pkg::MODE_SORTED;

    qres_t       pending_q [$];
    int          err_cnt = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          idle_cyc = 0;
    dir_row_t    dir_tab [10];

    function automatic qres_t queue_apply(logic cmd, logic [7:0] id, logic [15:0] key);
        qres_t r;
        int    pos;
        r = '0;
        if (cmd == srq_pkg::CMD_INSERT) begin
            if (mdl_fill >= srq_pkg::QUEUE_DEPTH) begin
                r.status = srq_pkg::ST_FULL;
            end else begin
                pos = mdl_fill;
                // lowest slot whose key is strictly greater keeps equal keys in order
                if (mdl_sorted == srq_pkg::MODE_SORTED) begin
                    for (int i = mdl_fill - 1; i >= 0; i--)
                        if (mdl_key[i] > key) pos = i;
                end
                for (int i = mdl_fill; i > pos; i--) begin
                    mdl_key[i] = mdl_key[i-1];
                    mdl_id[i]  = mdl_id[i-1];
                end
                mdl_key[pos] = key;
                mdl_id[pos]  = id;
                mdl_fill++;
            end
        end else if (mdl_fill == 0) begin
            r.status = srq_pkg::ST_EMPTY;
        end else begin
            r.pid  = mdl_id[0];
            r.pkey = mdl_key[0];
            for (int i = 1; i < mdl_fill; i++) begin
                mdl_key[i-1] = mdl_key[i];
                mdl_id[i-1]  = mdl_id[i];
            end
            mdl_fill--;
        end
        r.cnt  = mdl_fill[4:0];
        r.hv   = (mdl_fill != 0);
        r.hkey = (mdl_fill != 0) ? mdl_key[0] : '0;
        return r;
    endfunction

    task automatic field_chk(string nm, logic [31:0] ev, logic [31:0] av);
        if (ev !== av) begin
            $error("%s: expected %0h, got %0h", nm, ev, av);
            err_cnt++;
        end
    endtask

    // result checker
    always @(posedge aclk) begin : result_mon
        qres_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_q.size() == 0) begin
                $error("result item with no command pending");
                err_cnt++;
            end else begin
                w = pending_q[0];
                pending_q.delete(0);
                field_chk("status", 32'(w.status), 32'(m_tuser));
                field_chk("popped_id", 32'(w.pid), 32'(m_tdata[7:0]));
                field_chk("popped_key", 32'(w.pkey), 32'(m_tdata[23:8]));
                field_chk("entry_count", 32'(w.cnt), 32'(m_tdata[28:24]));
                field_chk("head_valid", 32'(w.hv), 32'(m_tdata[29]));
                field_chk("head_key", 32'(w.hkey), 32'(m_tdata[45:30]));
            end
        end
    end

    always @(negedge aclk)
        m_tready = ($urandom_range(0, 99) >= stall_pct);

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cyc = 0;
        else
            idle_cyc++;
        if (idle_cyc >= WDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic push_cmd(logic cmd, logic [7:0] id, logic [15:0] key, bit typed,
                            qres_t want);
        qres_t got;
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {key, id};
        do @(posedge aclk); while (!s_tready);
        got = queue_apply(cmd, id, key);
        pending_q.insert(pending_q.size(), typed ? want : got);
    endtask

    // valid stays high after the last item until the next falling edge
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_q.size() != 0) @(negedge aclk);
    endtask

    task automatic apb_xfer(bit wr, logic [2:0] addr, logic [31:0] wdata,
                            output logic [31:0] rdata);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = wdata;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_order_mode(logic mode);
        logic [31:0] rd;
        apb_xfer(1'b1, REG_ORDER_MODE, {31'd0, mode}, rd);
        mdl_sorted = mode;
        apb_xfer(1'b0, REG_ORDER_MODE, '0, rd);
        field_chk("order_mode readback", {31'd0, mode}, rd);
    endtask

    initial begin
        logic [31:0] rd;
        logic        cmd;
        logic [15:0] key;
        int          ins_pct;
        int          mode;

        dir_tab = '{
            '{srq_pkg::CMD_POP,    8'h00, 16'h0000, 1,  1'b1,
              '{srq_pkg::ST_EMPTY, 8'h00, 16'h0, 5'd0, 1'b0, 16'h0}},
            '{srq_pkg::CMD_INSERT, 8'hFF, 16'hFFFF, 1,  1'b1,
              '{srq_pkg::ST_OK, 8'h00, 16'h0, 5'd1, 1'b1, 16'hFFFF}},
            '{srq_pkg::CMD_INSERT, 8'h00, 16'h0000, 1,  1'b1,
              '{srq_pkg::ST_OK, 8'h00, 16'h0, 5'd2, 1'b1, 16'h0}},
            '{srq_pkg::CMD_INSERT, 8'h01, 16'h0000, 1,  1'b0, '0},
            '{srq_pkg::CMD_INSERT, 8'h55, 16'h1234, 13, 1'b0, '0},
            '{srq_pkg::CMD_INSERT, 8'h77, 16'h0000, 1,  1'b1,
              '{srq_pkg::ST_FULL, 8'h00, 16'h0, 5'd16, 1'b1, 16'h0}},
            '{srq_pkg::CMD_POP,    8'hFF, 16'hFFFF, 1,  1'b1,
              '{srq_pkg::ST_OK, 8'h00, 16'h0, 5'd15, 1'b1, 16'h0}},
            '{srq_pkg::CMD_POP,    8'h00, 16'h0000, 1,  1'b1,
              '{srq_pkg::ST_OK, 8'h01, 16'h0, 5'd14, 1'b1, 16'h1234}},
            '{srq_pkg::CMD_POP,    8'hAA, 16'h5555, 1,  1'b0, '0},
            '{srq_pkg::CMD_INSERT, 8'hAA, 16'hFFFF, 1,  1'b0, '0}
        };

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        apb_xfer(1'b0, REG_ORDER_MODE, '0, rd);
        field_chk("order_mode after reset", {31'd0, srq_pkg::MODE_SORTED}, rd);

        foreach (dir_tab[r])
            repeat (dir_tab[r].reps)
                push_cmd(dir_tab[r].cmd, dir_tab[r].id, dir_tab[r].key, dir_tab[r].typed,
                         dir_tab[r].want);

        // queue is kept populated across phases, so mode flips hit stored entries
        for (int ph = 0; ph < 8; ph++) begin
            wait_drained();
            repeat (4) @(negedge aclk);
            mode = (ph + ph / 4) % 2;
            set_order_mode(mode ? srq_pkg::MODE_SORTED : srq_pkg::MODE_ARRIVAL);
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 66; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 66; end
                default: begin send_idle_pct = 30; stall_pct = 30; end
            endcase
            ins_pct = 50;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 16 == 0) begin
                    case ($urandom_range(0, 3))
                        0: ins_pct = 25;
                        1: ins_pct = 50;
                        2: ins_pct = 75;
                        default: ins_pct = 90;
                    endcase
                end
                if (n == PHASE_ITEMS / 2 && ph % 4 == 3)
                    wait_drained();
                cmd = ($urandom_range(0, 99) < ins_pct) ? srq_pkg::CMD_INSERT
                                                         : srq_pkg::CMD_POP;
                case ($urandom_range(0, 3))
                    0: key = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    1: key = 16'($urandom_range(0, 7));   // many ties
                    default: key = 16'($urandom);
                endcase
                push_cmd(cmd, 8'($urandom), key, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (4) @(posedge aclk);
        if (err_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
`default_nettype wire

// ===== stable_sorted_ready_queue.f =====
src/srq_pkg.sv
src/srq_cell.sv
src/stable_sorted_ready_queue.sv
bench/tb.sv
